/* hw/rtl/ils_pkg.sv */
// Shared widths, operation codes and status codes of the indexed list store.
package ils_pkg;

  localparam int unsigned ILS_CAPACITY = 64;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIDX_W   = 6;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 3'd0,
    FUNC_INSERT = 3'd1,
    FUNC_EDIT   = 3'd2,
    FUNC_DELETE = 3'd3,
    FUNC_READ   = 3'd4,
    FUNC_FIND   = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

endpackage

/* hw/rtl/ils_mem.sv */
// Entry store: one write port, one read port, registered read data.
module ils_mem
  import ils_pkg::*;
#(
  parameter int unsigned Capacity = ILS_CAPACITY,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] mem [Capacity];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ils_ctrl.sv */
// Sequencer: decodes a request, walks the store and builds the result.
module ils_ctrl
  import ils_pkg::*;
#(
  parameter int unsigned Capacity = ILS_CAPACITY,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CW = $clog2(Capacity + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [FUNC_W-1:0]          func_i,
  input  logic [INDEX_W-1:0]         index_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [VALUE_W-1:0]  read_value_o,
  output logic [FIDX_W-1:0]          found_index_o,
  output logic [COUNT_W-1:0]         entry_count_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [VALUE_W-1:0]         mem_wdata_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [VALUE_W-1:0]         mem_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_PUT
  } state_e;

  localparam logic [CW-1:0] CapCount = CW'(Capacity);

  state_e              state_q, state_d;
  func_e               op_q, op_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       end_q, end_d;
  logic                rv_q, rv_d;
  logic [AW-1:0]       raddr_q, raddr_d;
  logic [CW-1:0]       count_q, count_d;
  logic [VALUE_W-1:0]  rd_q, rd_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [VALUE_W-1:0]  rdv_q, rdv_d;
  logic [FIDX_W-1:0]   fidx_q, fidx_d;

  logic [CW+INDEX_W-1:0]  idx_ext, count_ext;
  logic [AW+INDEX_W-1:0]  idx_wide;
  logic [AW+FIDX_W-1:0]   fidx_wide;
  logic [CW+COUNT_W-1:0]  count_wide;
  logic [AW-1:0]          idx_a, last_a;
  logic                   idx_ok, hit_idx, match;

  assign idx_ext    = {{CW{1'b0}}, index_i};
  assign count_ext  = {{INDEX_W{1'b0}}, count_q};
  assign idx_ok     = idx_ext < count_ext;
  assign idx_wide   = {{AW{1'b0}}, index_i};
  assign idx_a      = idx_wide[AW-1:0];
  assign last_a     = AW'(count_q - CW'(1));
  assign fidx_wide  = {{FIDX_W{1'b0}}, raddr_q};
  assign count_wide = {{COUNT_W{1'b0}}, count_q};
  assign hit_idx    = raddr_q == idx_q;
  assign match      = mem_rdata_i == val_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    val_d       = val_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    rv_d        = 1'b0;
    raddr_d     = raddr_q;
    count_d     = count_q;
    rd_d        = rd_q;
    done_d      = 1'b0;
    status_d    = status_q;
    rdv_d       = rdv_q;
    fidx_d      = fidx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = func_e'(func_i);
          idx_d    = idx_a;
          val_d    = value_i;
          done_d   = 1'b1;
          status_d = STAT_OK;
          rdv_d    = '0;
          fidx_d   = '0;
          case (func_e'(func_i))
            FUNC_APPEND: begin
              if (count_q == CapCount) begin
                status_d = STAT_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = count_q[AW-1:0];
                mem_wdata_o = value_i;
                count_d     = count_q + CW'(1);
              end
            end
            FUNC_INSERT: begin
              if (!idx_ok) begin
                status_d = STAT_BAD_INDEX;
              end else if (count_q == CapCount) begin
                status_d = STAT_FULL;
              end else begin
                done_d  = 1'b0;
                ptr_d   = last_a;
                end_d   = idx_a;
                state_d = S_WALK;
              end
            end
            FUNC_EDIT: begin
              if (!idx_ok) begin
                status_d = STAT_BAD_INDEX;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = idx_a;
                mem_wdata_o = value_i;
              end
            end
            FUNC_DELETE, FUNC_READ: begin
              if (!idx_ok) begin
                status_d = STAT_BAD_INDEX;
              end else begin
                done_d  = 1'b0;
                ptr_d   = idx_a;
                end_d   = (func_e'(func_i) == FUNC_READ) ? idx_a : last_a;
                state_d = S_WALK;
              end
            end
            FUNC_FIND: begin
              if (count_q == '0) begin
                status_d = STAT_NOT_FOUND;
              end else begin
                done_d  = 1'b0;
                ptr_d   = '0;
                end_d   = last_a;
                state_d = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK, S_DRAIN: begin
        // Handle the word read in the previous cycle.
        if (rv_q) begin
          case (op_q)
            FUNC_INSERT: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = raddr_q + AW'(1);
            end
            FUNC_DELETE: begin
              if (hit_idx) begin
                rd_d = mem_rdata_i;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = raddr_q - AW'(1);
              end
            end
            default: begin
            end
          endcase
        end

        if (state_q == S_WALK) begin
          rv_d    = 1'b1;
          raddr_d = ptr_q;
          if (ptr_q == end_q) begin
            state_d = S_DRAIN;
          end else if (op_q == FUNC_INSERT) begin
            ptr_d = ptr_q - AW'(1);
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end

        if (rv_q && op_q == FUNC_FIND && match) begin
          rv_d     = 1'b0;
          done_d   = 1'b1;
          status_d = STAT_OK;
          fidx_d   = fidx_wide[FIDX_W-1:0];
          state_d  = S_IDLE;
        end else if (state_q == S_DRAIN) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          case (op_q)
            FUNC_INSERT: begin
              done_d  = 1'b0;
              state_d = S_PUT;
            end
            FUNC_DELETE: begin
              count_d = count_q - CW'(1);
              rdv_d   = hit_idx ? mem_rdata_i : rd_q;
            end
            FUNC_READ: begin
              rdv_d = mem_rdata_i;
            end
            FUNC_FIND: begin
              status_d = STAT_NOT_FOUND;
            end
            default: begin
            end
          endcase
        end
      end

      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = val_q;
        count_d     = count_q + CW'(1);
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= FUNC_APPEND;
      idx_q    <= '0;
      val_q    <= '0;
      ptr_q    <= '0;
      end_q    <= '0;
      rv_q     <= 1'b0;
      raddr_q  <= '0;
      count_q  <= '0;
      rd_q     <= '0;
      done_q   <= 1'b0;
      status_q <= STAT_OK;
      rdv_q    <= '0;
      fidx_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      idx_q    <= idx_d;
      val_q    <= val_d;
      ptr_q    <= ptr_d;
      end_q    <= end_d;
      rv_q     <= rv_d;
      raddr_q  <= raddr_d;
      count_q  <= count_d;
      rd_q     <= rd_d;
      done_q   <= done_d;
      status_q <= status_d;
      rdv_q    <= rdv_d;
      fidx_q   <= fidx_d;
    end
  end

  assign busy          = state_q != S_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = rdv_q;
  assign found_index_o = fidx_q;
  assign entry_count_o = count_wide[COUNT_W-1:0];

endmodule

/* hw/rtl/indexed_list_store_top.sv */
// Top level of the indexed list store: sequencer plus entry memory.
//
//  Channel   | Direction | Handshake                  | Beat contents
//  ----------+-----------+----------------------------+-----------------------------------
//  request   | in        | start & !busy              | func_i, index_i, value_i
//  result    | out       | done_o, one cycle, no stall | status_o, read_value_o,
//            |           |                            | found_index_o, entry_count_o
//
// Cycles: append, edit, failed requests and unused codes return their result
// beat the cycle after acceptance and busy never rises. Read fetches one entry;
// insert walks down from the last entry to index, delete up from index to the
// last, find up from entry 0 until a match. The walk moves one entry per cycle,
// bounded by the one read and one write port (read one, write back the previous).
// Reset clears the entry count and the sequencer; memory contents are left
// as they are, since only entries below the count are ever read.
// The result beat cannot be stalled; a new request may be taken in the
// same cycle that the previous result beat is shown.
module indexed_list_store_top
  import ils_pkg::*;
#(
  parameter int unsigned Capacity = ILS_CAPACITY
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic [INDEX_W-1:0]        index_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      done_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic signed [VALUE_W-1:0] read_value_o,
  output logic [FIDX_W-1:0]         found_index_o,
  output logic [COUNT_W-1:0]        entry_count_o
);

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;

  // Memory port between sequencer and store.
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // Decode, walk the list and build each result beat.
  ils_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .found_index_o (found_index_o),
    .entry_count_o (entry_count_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // Hold the list words; read data arrives in the cycle after the address.
  ils_mem #(
    .Capacity (Capacity)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
